// ===== rtl/brfr_pkg.sv =====
// Shared types and constants for the byte ring FIFO with write reservation.
// Holds the command, status and state codes, the beat structs and the lane control struct.
// Depends on nothing; the RTL files refer to it by scoped names, the test files import it.
`timescale 1ns / 1ps

package brfr_pkg;

  // Fixed field widths.
  localparam int CMD_W      = 3;
  localparam int LEN_W      = 10;
  localparam int DATA_W     = 64;
  localparam int STAT_W     = 3;
  // Byte lanes, one bank each; a byte address picks its bank by its low bits.
  localparam int NUM_LANES  = 8;
  localparam int LANE_SEL_W = 3;
  localparam int NB_W       = 4;
  // Widest ring index that the lane control carries.
  localparam int BASE_W     = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE   = 3'd0,
    CMD_READ    = 3'd1,
    CMD_RESERVE = 3'd2,
    CMD_PWRITE  = 3'd3,
    CMD_COMMIT  = 3'd4,
    CMD_CLOSE   = 3'd5,
    CMD_SKIP    = 3'd6
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_CLOSED   = 3'd1,
    ST_BLOCK    = 3'd2,
    ST_BUSY     = 3'd3,
    ST_MISMATCH = 3'd4,
    ST_LONG     = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_PHB,
    S_RDB,
    S_SKIP,
    S_SKFIN
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [LEN_W-1:0]  length;
    logic [DATA_W-1:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  count;
    logic [DATA_W-1:0] read_data;
    logic              closed;
  } out_item_t;

  // One contiguous run of bytes that the lanes handle at once.
  typedef struct packed {
    logic [BASE_W-1:0] base;    // ring address of the first byte of the run
    logic [NB_W-1:0]   nbytes;  // bytes in the run
    logic [NB_W-1:0]   off;     // position of the first byte within the beat
    logic              we;
    logic              re;
  } lane_ctl_t;

endpackage

// ===== rtl/brfr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the byte bank of each lane; depends on nothing.
`timescale 1ns / 1ps

module brfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/brfr_lane.sv =====
// One byte lane: works out which byte of the run falls in its bank, and its row.
// Depends on brfr_pkg and brfr_ram.
`timescale 1ns / 1ps

module brfr_lane #(
  parameter int LANE = 0,
  parameter int IW   = 10,
  parameter int ROWS = 128,
  parameter int RW   = 7
) (
  input  logic                           clk,
  input  brfr_pkg::lane_ctl_t            ctl,
  input  logic [brfr_pkg::DATA_W-1:0]    wdata,
  output logic [7:0]                     rd_byte
);

  localparam int AW = IW + brfr_pkg::LANE_SEL_W;

  logic [brfr_pkg::LANE_SEL_W-1:0] k;
  logic                            active;
  logic [AW-1:0]                   addr;
  logic [RW-1:0]                   row;
  logic [brfr_pkg::NB_W-1:0]       sel;
  logic [7:0]                      wbyte;

  // Offset of this bank's byte within the run, and its ring address.
  always_comb begin
    k      = brfr_pkg::LANE_SEL_W'(LANE) - ctl.base[brfr_pkg::LANE_SEL_W-1:0];
    active = brfr_pkg::NB_W'(k) < ctl.nbytes;
    addr   = AW'(ctl.base[IW-1:0]) + AW'(k);
    row    = RW'(addr >> brfr_pkg::LANE_SEL_W);
    sel    = ctl.off + brfr_pkg::NB_W'(k);
    wbyte  = wdata[{sel[brfr_pkg::LANE_SEL_W-1:0], 3'b000} +: 8];
  end

  brfr_ram #(
    .WIDTH (8),
    .DEPTH (ROWS)
  ) u_bank (
    .clk   (clk),
    .we    (ctl.we & active),
    .waddr (row),
    .wdata (wbyte),
    .re    (ctl.re & active),
    .raddr (row),
    .rdata (rd_byte)
  );

endmodule

// ===== rtl/brfr_merge.sv =====
// Merge stage: gathers the bytes that the lanes read back into beat order.
// Depends on brfr_pkg.
`timescale 1ns / 1ps

module brfr_merge (
  input  logic [brfr_pkg::NUM_LANES-1:0][7:0] lane_q,
  input  brfr_pkg::lane_ctl_t                 ctl,
  output logic [brfr_pkg::DATA_W-1:0]         data
);

  // Byte j of the beat is byte j - off of the run, found in the bank it maps to.
  always_comb begin
    data = '0;
    for (int j = 0; j < brfr_pkg::NUM_LANES; j++) begin
      logic [brfr_pkg::NB_W-1:0]       k;
      logic [brfr_pkg::LANE_SEL_W-1:0] lane;
      k    = brfr_pkg::NB_W'(j) - ctl.off;
      lane = ctl.base[brfr_pkg::LANE_SEL_W-1:0] + k[brfr_pkg::LANE_SEL_W-1:0];
      if ((brfr_pkg::NB_W'(j) >= ctl.off) && (k < ctl.nbytes)) begin
        data[8*j +: 8] = lane_q[lane];
      end
    end
  end

endmodule

// ===== rtl/byte_ring_fifo_with_reservation_core.sv =====
// Byte ring FIFO with write reservation: one command per beat, one result per command.
// The result strobe is registered as the block leaves its last state: PHB for most commands,
// RDB for read (banked registered read, run split at the ring end) and SKFIN for skip (length
// reduced modulo the ring size); busy drops with the strobe, so one command is taken at a time.
// Synchronous active-low reset clears indices, reservation and closed flag; the byte
// banks are not cleared. Results are a one-cycle strobe and cannot be held off.
`timescale 1ns / 1ps

module byte_ring_fifo_with_reservation_core #(
  parameter int DEPTH     = 1024,
  parameter int MAX_BYTES = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  brfr_pkg::in_item_t   in_item,
  output logic                 out_valid,
  output brfr_pkg::out_item_t  out_item
);

  localparam int IW   = $clog2(DEPTH);
  localparam int ROWS = (DEPTH + brfr_pkg::NUM_LANES - 1) / brfr_pkg::NUM_LANES;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW   = ((IW > brfr_pkg::LEN_W) ? IW : brfr_pkg::LEN_W) + 1;
  localparam int LW   = brfr_pkg::LEN_W;
  localparam int NW   = brfr_pkg::NB_W;
  // Reciprocal of the ring size, exact for every length that the field can carry.
  localparam int     RSH   = LW + IW;
  localparam int     MW    = LW + 2;
  localparam longint RECIP = ((longint'(1) << RSH) + longint'(DEPTH) - longint'(1)) /
                             longint'(DEPTH);

  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
  localparam logic [LW-1:0] MAXB_C   = LW'(MAX_BYTES);
  localparam logic [MW-1:0] RECIP_C  = MW'(RECIP);

  brfr_pkg::state_t state_r, state_nxt;

  logic [brfr_pkg::CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [LW-1:0]               len_r, len_nxt;
  logic [brfr_pkg::DATA_W-1:0] data_r, data_nxt;
  logic [IW-1:0]               write_idx_r, write_idx_nxt;
  logic [IW-1:0]               read_idx_r, read_idx_nxt;
  logic [IW-1:0]               resv_idx_r, resv_idx_nxt;
  logic [LW-1:0]               resv_rem_r, resv_rem_nxt;
  logic                        resv_act_r, resv_act_nxt;
  logic                        closed_r, closed_nxt;
  logic [brfr_pkg::STAT_W-1:0] res_status_r, res_status_nxt;
  logic [LW-1:0]               res_count_r, res_count_nxt;
  logic [brfr_pkg::DATA_W-1:0] acc_r, acc_nxt;
  brfr_pkg::lane_ctl_t         ctl_q_r, ctl;
  logic [LW-1:0]               skip_r, skip_nxt;
  logic [LW-1:0]               skip_q_r, skip_q_nxt;
  logic                        wr_op_r, wr_op_nxt;
  logic                        rd_op_r, rd_op_nxt;
  logic [NW-1:0]               na_r, na_nxt;
  logic [NW-1:0]               nb_r, nb_nxt;
  logic                        out_valid_r, out_valid_nxt;
  brfr_pkg::out_item_t         out_item_r, out_item_nxt;

  logic [CW-1:0] wr_c, rd_c, rsv_c, len_c, base_c;
  logic [CW-1:0] diff_c, free_c, avail_c, room_c;
  logic [CW-1:0] adv_base, adv_len, adv_sum, adv_c;
  logic [NW-1:0] n_a, n_b;
  logic          too_long;
  logic [LW+MW-1:0] skip_prod;
  logic [LW-1:0]    skip_quot;
  logic [brfr_pkg::NUM_LANES-1:0][7:0] lane_q;
  logic [brfr_pkg::DATA_W-1:0]         merge_data;

  assign busy      = (state_r != brfr_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Ring occupancy, split of a run at the ring end, and index advance.
  always_comb begin
    wr_c    = CW'(write_idx_r);
    rd_c    = CW'(read_idx_r);
    rsv_c   = CW'(resv_idx_r);
    len_c   = CW'(len_r);
    diff_c  = (rd_c >= wr_c) ? rd_c - wr_c : rd_c + DEPTH_C - wr_c;
    free_c  = (diff_c == '0) ? DEPTH_C - CW'(1) : diff_c - CW'(1);
    avail_c = (wr_c >= rd_c) ? wr_c - rd_c : wr_c + DEPTH_C - rd_c;
    case (cmd_r)
      brfr_pkg::CMD_READ:   base_c = rd_c;
      brfr_pkg::CMD_PWRITE: base_c = rsv_c;
      default:              base_c = wr_c;
    endcase
    room_c   = DEPTH_C - base_c;
    n_a      = (len_c <= room_c) ? NW'(len_r) : NW'(room_c);
    n_b      = NW'(len_r) - n_a;
    too_long = (len_r > MAXB_C);
    adv_base = (state_r == brfr_pkg::S_SKFIN) ? rd_c : base_c;
    adv_len  = (state_r == brfr_pkg::S_SKFIN) ? CW'(skip_r) : len_c;
    adv_sum  = adv_base + adv_len;
    adv_c    = (adv_sum >= DEPTH_C) ? adv_sum - DEPTH_C : adv_sum;
    // Whole ring turns in the skip length, by reciprocal multiplication.
    skip_prod = (LW+MW)'(len_r) * (LW+MW)'(RECIP_C);
    skip_quot = LW'(skip_prod >> RSH);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      brfr_pkg::S_IDLE:  if (start) state_nxt = brfr_pkg::S_EVAL;
      brfr_pkg::S_EVAL: begin
        state_nxt = (cmd_r == brfr_pkg::CMD_SKIP) ? brfr_pkg::S_SKIP : brfr_pkg::S_PHB;
      end
      brfr_pkg::S_PHB:   state_nxt = rd_op_r ? brfr_pkg::S_RDB : brfr_pkg::S_IDLE;
      brfr_pkg::S_RDB:   state_nxt = brfr_pkg::S_IDLE;
      brfr_pkg::S_SKIP:  state_nxt = brfr_pkg::S_SKFIN;
      brfr_pkg::S_SKFIN: state_nxt = brfr_pkg::S_IDLE;
      default:           state_nxt = brfr_pkg::S_IDLE;
    endcase
  end

  // Command evaluation, lane control and result assembly.
  always_comb begin
    cmd_nxt        = cmd_r;
    len_nxt        = len_r;
    data_nxt       = data_r;
    write_idx_nxt  = write_idx_r;
    read_idx_nxt   = read_idx_r;
    resv_idx_nxt   = resv_idx_r;
    resv_rem_nxt   = resv_rem_r;
    resv_act_nxt   = resv_act_r;
    closed_nxt     = closed_r;
    res_status_nxt = res_status_r;
    res_count_nxt  = res_count_r;
    acc_nxt        = acc_r;
    skip_nxt       = skip_r;
    skip_q_nxt     = skip_q_r;
    wr_op_nxt      = wr_op_r;
    rd_op_nxt      = rd_op_r;
    na_nxt         = na_r;
    nb_nxt         = nb_r;
    out_valid_nxt  = 1'b0;
    out_item_nxt   = out_item_r;
    ctl            = '0;

    unique case (state_r)
      brfr_pkg::S_IDLE: begin
        if (start) begin
          cmd_nxt  = in_item.command;
          len_nxt  = in_item.length;
          data_nxt = in_item.write_data;
        end
      end

      brfr_pkg::S_EVAL: begin
        res_status_nxt = brfr_pkg::ST_OK;
        res_count_nxt  = '0;
        wr_op_nxt      = 1'b0;
        rd_op_nxt      = 1'b0;
        na_nxt         = n_a;
        nb_nxt         = n_b;
        case (cmd_r)
          brfr_pkg::CMD_WRITE: begin
            if (closed_r)            res_status_nxt = brfr_pkg::ST_CLOSED;
            else if (resv_act_r)     res_status_nxt = brfr_pkg::ST_BUSY;
            else if (too_long)       res_status_nxt = brfr_pkg::ST_LONG;
            else if (len_c > free_c) res_status_nxt = brfr_pkg::ST_BLOCK;
            else begin
              wr_op_nxt     = 1'b1;
              res_count_nxt = len_r;
              write_idx_nxt = IW'(adv_c);
            end
          end
          brfr_pkg::CMD_READ: begin
            if (too_long) res_status_nxt = brfr_pkg::ST_LONG;
            else if (len_c > avail_c) begin
              res_status_nxt = closed_r ? brfr_pkg::ST_CLOSED : brfr_pkg::ST_BLOCK;
            end else begin
              rd_op_nxt     = 1'b1;
              res_count_nxt = len_r;
              read_idx_nxt  = IW'(adv_c);
            end
          end
          brfr_pkg::CMD_RESERVE: begin
            if (closed_r)            res_status_nxt = brfr_pkg::ST_CLOSED;
            else if (resv_act_r)     res_status_nxt = brfr_pkg::ST_BUSY;
            else if (len_c > free_c) res_status_nxt = brfr_pkg::ST_BLOCK;
            else begin
              resv_idx_nxt  = write_idx_r;
              resv_rem_nxt  = len_r;
              resv_act_nxt  = 1'b1;
              res_count_nxt = len_r;
            end
          end
          brfr_pkg::CMD_PWRITE: begin
            if (closed_r)                 res_status_nxt = brfr_pkg::ST_CLOSED;
            else if (too_long)            res_status_nxt = brfr_pkg::ST_LONG;
            else if (len_r > resv_rem_r)  res_status_nxt = brfr_pkg::ST_MISMATCH;
            else begin
              wr_op_nxt     = 1'b1;
              res_count_nxt = len_r;
              resv_idx_nxt  = IW'(adv_c);
              resv_rem_nxt  = resv_rem_r - len_r;
            end
          end
          brfr_pkg::CMD_COMMIT: begin
            if (closed_r) res_status_nxt = brfr_pkg::ST_CLOSED;
            else if (!resv_act_r || (resv_rem_r != '0)) begin
              res_status_nxt = brfr_pkg::ST_MISMATCH;
            end else begin
              write_idx_nxt = resv_idx_r;
              resv_act_nxt  = 1'b0;
            end
          end
          brfr_pkg::CMD_CLOSE: closed_nxt = 1'b1;
          brfr_pkg::CMD_SKIP: begin
            res_count_nxt = len_r;
            skip_nxt      = len_r;
            skip_q_nxt    = skip_quot;
          end
          default: ;
        endcase
        // First run of bytes, up to the ring end.
        ctl.base   = brfr_pkg::BASE_W'(base_c);
        ctl.nbytes = n_a;
        ctl.off    = '0;
        ctl.we     = wr_op_nxt;
        ctl.re     = rd_op_nxt;
      end

      brfr_pkg::S_PHB: begin
        // Second run, wrapped to the ring start; first-run read data is back.
        ctl.base   = '0;
        ctl.nbytes = nb_r;
        ctl.off    = na_r;
        ctl.we     = wr_op_r;
        ctl.re     = rd_op_r;
        acc_nxt    = merge_data;
        if (!rd_op_r) begin
          out_valid_nxt          = 1'b1;
          out_item_nxt.status    = res_status_r;
          out_item_nxt.count     = res_count_r;
          out_item_nxt.read_data = '0;
          out_item_nxt.closed    = closed_r;
        end
      end

      brfr_pkg::S_RDB: begin
        out_valid_nxt          = 1'b1;
        out_item_nxt.status    = res_status_r;
        out_item_nxt.count     = res_count_r;
        out_item_nxt.read_data = acc_r | merge_data;
        out_item_nxt.closed    = closed_r;
      end

      brfr_pkg::S_SKIP: begin
        // Remainder of the skip length modulo the ring size.
        skip_nxt = skip_r - LW'(skip_q_r * DEPTH_C);
      end

      brfr_pkg::S_SKFIN: begin
        read_idx_nxt           = IW'(adv_c);
        out_valid_nxt          = 1'b1;
        out_item_nxt.status    = res_status_r;
        out_item_nxt.count     = res_count_r;
        out_item_nxt.read_data = '0;
        out_item_nxt.closed    = closed_r;
      end

      default: ;
    endcase
  end

  // Byte lanes, one bank each.
  for (genvar b = 0; b < brfr_pkg::NUM_LANES; b++) begin : g_lane
    brfr_lane #(
      .LANE (b),
      .IW   (IW),
      .ROWS (ROWS),
      .RW   (RW)
    ) u_lane (
      .clk     (clk),
      .ctl     (ctl),
      .wdata   (data_r),
      .rd_byte (lane_q[b])
    );
  end

  // Merge the bytes read in the previous cycle.
  brfr_merge u_merge (
    .lane_q (lane_q),
    .ctl    (ctl_q_r),
    .data   (merge_data)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= brfr_pkg::S_IDLE;
      write_idx_r <= '0;
      read_idx_r  <= '0;
      resv_idx_r  <= '0;
      resv_rem_r  <= '0;
      resv_act_r  <= 1'b0;
      closed_r    <= 1'b0;
      wr_op_r     <= 1'b0;
      rd_op_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      write_idx_r <= write_idx_nxt;
      read_idx_r  <= read_idx_nxt;
      resv_idx_r  <= resv_idx_nxt;
      resv_rem_r  <= resv_rem_nxt;
      resv_act_r  <= resv_act_nxt;
      closed_r    <= closed_nxt;
      wr_op_r     <= wr_op_nxt;
      rd_op_r     <= rd_op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    len_r        <= len_nxt;
    data_r       <= data_nxt;
    res_status_r <= res_status_nxt;
    res_count_r  <= res_count_nxt;
    acc_r        <= acc_nxt;
    ctl_q_r      <= ctl;
    skip_r       <= skip_nxt;
    skip_q_r     <= skip_q_nxt;
    na_r         <= na_nxt;
    nb_r         <= nb_nxt;
    out_item_r   <= out_item_nxt;
  end

  // A result strobe leaves the block free for the next command.
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while a command is still in progress");

  // An accepted command keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted command did not make the block busy");

  // Reserved bytes can only remain while a reservation is open.
  a_rem_active: assert property (@(posedge clk) disable iff (!rst_n)
    (resv_rem_r != '0) |-> resv_act_r)
    else $error("reservation bytes remain without an open reservation");

  // Any error reports no bytes and no data.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status != brfr_pkg::ST_OK)) |->
      ((out_item.count == '0) && (out_item.read_data == '0)))
    else $error("error result carries a count or data");

endmodule

// ===== test/brfr_checker.sv =====
// Result checker for the byte ring FIFO with write reservation.
// Watches the command and result channels, predicts every reply and compares it field by field.
// Depends on brfr_pkg for the beat structs and the command and status codes.
`timescale 1ns / 1ps

module brfr_checker
  import brfr_pkg::*;
#(
  parameter int DEPTH     = 1024,
  parameter int MAX_BYTES = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  out_item_t out_item,
  output int        mismatch_total,
  output int        replies_owed
);

  // Shadow copy of the ring and its pointers.
  logic [7:0] ring_bytes [DEPTH];
  int         wr_ptr;
  int         rd_ptr;
  int         rsv_ptr;
  int         rsv_left;
  logic       rsv_open;
  logic       fifo_closed;

  // Replies owed by the block, oldest first.
  out_item_t  owed_q[$];
  out_item_t  want;
  int         errs = 0;

  // Apply one command to the shadow state and return the reply it should get.
  function automatic out_item_t apply_command(in_item_t c);
    out_item_t r;
    int        n;
    int        room;
    int        avail;
    int        i;
    r     = '0;
    n     = int'(c.length);
    room  = (rd_ptr - wr_ptr + DEPTH) % DEPTH;
    room  = (room == 0) ? DEPTH - 1 : room - 1;
    avail = (wr_ptr - rd_ptr + DEPTH) % DEPTH;
    r.status = ST_OK;
    case (c.command)
      CMD_WRITE: begin
        if (fifo_closed) r.status = ST_CLOSED;
        else if (rsv_open) r.status = ST_BUSY;
        else if (n > MAX_BYTES) r.status = ST_LONG;
        else if (n > room) r.status = ST_BLOCK;
        else begin
          for (i = 0; i < n; i++) ring_bytes[(wr_ptr + i) % DEPTH] = c.write_data[8*i +: 8];
          wr_ptr  = (wr_ptr + n) % DEPTH;
          r.count = LEN_W'(n);
        end
      end
      CMD_READ: begin
        // Reading stays legal after close; a short ring then reports closed.
        if (n > MAX_BYTES) r.status = ST_LONG;
        else if (n > avail) r.status = fifo_closed ? ST_CLOSED : ST_BLOCK;
        else begin
          for (i = 0; i < n; i++) r.read_data[8*i +: 8] = ring_bytes[(rd_ptr + i) % DEPTH];
          rd_ptr  = (rd_ptr + n) % DEPTH;
          r.count = LEN_W'(n);
        end
      end
      CMD_RESERVE: begin
        if (fifo_closed) r.status = ST_CLOSED;
        else if (rsv_open) r.status = ST_BUSY;
        else if (n > room) r.status = ST_BLOCK;
        else begin
          rsv_ptr  = wr_ptr;
          rsv_left = n;
          rsv_open = 1'b1;
          r.count  = LEN_W'(n);
        end
      end
      CMD_PWRITE: begin
        // No check of an open claim: without one only a zero length gets through.
        if (fifo_closed) r.status = ST_CLOSED;
        else if (n > MAX_BYTES) r.status = ST_LONG;
        else if (n > rsv_left) r.status = ST_MISMATCH;
        else begin
          for (i = 0; i < n; i++) ring_bytes[(rsv_ptr + i) % DEPTH] = c.write_data[8*i +: 8];
          rsv_ptr  = (rsv_ptr + n) % DEPTH;
          rsv_left = rsv_left - n;
          r.count  = LEN_W'(n);
        end
      end
      CMD_COMMIT: begin
        if (fifo_closed) r.status = ST_CLOSED;
        else if (!rsv_open || rsv_left != 0) r.status = ST_MISMATCH;
        else begin
          wr_ptr   = rsv_ptr;
          rsv_open = 1'b0;
        end
      end
      CMD_CLOSE: fifo_closed = 1'b1;
      CMD_SKIP: begin
        rd_ptr  = (rd_ptr + n) % DEPTH;
        r.count = LEN_W'(n);
      end
      default: ;
    endcase
    r.closed = fifo_closed;
    return r;
  endfunction

  // Retire result beats against the oldest prediction, then log accepted commands.
  always @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr      = 0;
      rd_ptr      = 0;
      rsv_ptr     = 0;
      rsv_left    = 0;
      rsv_open    = 1'b0;
      fifo_closed = 1'b0;
      owed_q.delete();
    end else begin
      if (out_valid) begin
        if (owed_q.size() == 0) begin
          $error("unexpected result beat: status %0d count %0d",
                 out_item.status, out_item.count);
          errs++;
        end else begin
          want = owed_q.pop_front();
          if (out_item.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_item.status);
            errs++;
          end
          if (out_item.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, out_item.count);
            errs++;
          end
          if (out_item.read_data !== want.read_data) begin
            $error("read_data: expected %h, got %h", want.read_data, out_item.read_data);
            errs++;
          end
          if (out_item.closed !== want.closed) begin
            $error("closed: expected %0d, got %0d", want.closed, out_item.closed);
            errs++;
          end
        end
      end
      if (start && !busy) owed_q.push_back(apply_command(in_item));
    end
    mismatch_total <= errs;
    replies_owed   <= owed_q.size();
  end

endmodule

// ===== test/tb.sv =====
// Top of the byte ring FIFO testbench: clock, reset, command stimulus and the verdict.
// Drives byte_ring_fifo_with_reservation_core and leaves all checking to brfr_checker.
// Depends on brfr_pkg, the block itself and test/brfr_checker.sv.
`timescale 1ns / 1ps

module tb;
  import brfr_pkg::*;

  localparam int               DEPTH       = 1024;
  localparam int               LANE_BYTES  = 8;
  localparam int               ITEM_TARGET = 1700;
  // The one command code that the block leaves unused.
  localparam logic [CMD_W-1:0] CMD_SPARE   = 3'd7;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  logic      out_valid;
  in_item_t  in_item;
  out_item_t out_item;
  int        mismatch_total;
  int        replies_owed;
  int        beats_sent;
  int        burst_left;

  byte_ring_fifo_with_reservation_core #(
    .DEPTH(DEPTH),
    .MAX_BYTES(LANE_BYTES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_item(out_item)
  );

  brfr_checker #(
    .DEPTH(DEPTH),
    .MAX_BYTES(LANE_BYTES)
  ) chk (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_item(out_item),
    .mismatch_total(mismatch_total),
    .replies_owed(replies_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #5_000_000;
    $display("tb: errors");
    $finish;
  end

  function automatic logic [DATA_W-1:0] rand_bytes();
    return {$urandom, $urandom};
  endfunction

  // Mostly legal data lengths, with some over the lane count up to the field maximum.
  function automatic int data_len();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return LANE_BYTES + 1;
    if (pick == 1) return ($urandom_range(0, 1) == 0) ? 1023 : $urandom_range(10, 1022);
    return $urandom_range(0, LANE_BYTES);
  endfunction

  // Send one command beat; bursts of random length with idle gaps between them.
  task automatic issue(input logic [CMD_W-1:0] op, input int len, input logic [DATA_W-1:0] data);
    in_item_t beat;
    int       gap;
    beat.command    = op;
    beat.length     = LEN_W'(len);
    beat.write_data = data;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 4);
      repeat (gap) begin
        @(negedge clk);
        start              <= 1'b0;
        in_item.write_data <= rand_bytes();
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    @(negedge clk);
    start   <= 1'b1;
    in_item <= beat;
    do @(posedge clk); while (busy);
    beats_sent++;
  endtask

  // One reservation: claim, fill in chunks with other traffic mixed in, then publish.
  task automatic reservation_run();
    int total;
    int left;
    int chunk;
    total = ($urandom_range(0, 39) == 0) ? $urandom_range(64, 1023) : $urandom_range(0, 40);
    issue(CMD_RESERVE, total, rand_bytes());
    left = total;
    while (left > 0) begin
      case ($urandom_range(0, 19))
        0: issue(CMD_COMMIT, 0, rand_bytes());
        1: begin
          issue(CMD_PWRITE, (left < LANE_BYTES) ? left + 1 : $urandom_range(9, 1023),
                rand_bytes());
        end
        2: issue(CMD_WRITE, data_len(), rand_bytes());
        3: issue(CMD_READ, data_len(), rand_bytes());
        4: issue(CMD_SKIP, $urandom_range(0, LANE_BYTES), rand_bytes());
        // A zero claim is harmless even when the outer claim was refused.
        5: issue(CMD_RESERVE, 0, rand_bytes());
        default: begin
          chunk = $urandom_range(0, (left < LANE_BYTES) ? left : LANE_BYTES);
          issue(CMD_PWRITE, chunk, rand_bytes());
          left = left - chunk;
        end
      endcase
    end
    issue(CMD_COMMIT, 0, rand_bytes());
    if ($urandom_range(0, 3) == 0) issue(CMD_COMMIT, 0, rand_bytes());
  endtask

  initial begin : stimulus
    int               mode;
    int               pick;
    int               wr_w;
    int               rd_w;
    logic [CMD_W-1:0] op;
    start      = 1'b0;
    in_item    = '0;
    rst_n      = 1'b0;
    beats_sent = 0;
    burst_left = 0;
    mode       = 2;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty and full lengths, every error but closed, a reservation from start to end.
    issue(CMD_WRITE, 0, rand_bytes());
    issue(CMD_WRITE, 8, 64'hFFFF_FFFF_FFFF_FFFF);
    issue(CMD_READ, 8, rand_bytes());
    issue(CMD_WRITE, 9, rand_bytes());
    issue(CMD_WRITE, 1023, rand_bytes());
    issue(CMD_READ, 1, rand_bytes());
    issue(CMD_READ, 1023, rand_bytes());
    issue(CMD_WRITE, 5, 64'h0123_4567_89AB_CDEF);
    issue(CMD_READ, 3, rand_bytes());
    issue(CMD_RESERVE, 4, rand_bytes());
    issue(CMD_WRITE, 1, rand_bytes());
    issue(CMD_RESERVE, 1, rand_bytes());
    issue(CMD_COMMIT, 0, rand_bytes());
    issue(CMD_PWRITE, 5, rand_bytes());
    issue(CMD_PWRITE, 9, rand_bytes());
    issue(CMD_PWRITE, 4, 64'h0000_0000_A55A_0FF0);
    issue(CMD_PWRITE, 0, rand_bytes());
    issue(CMD_COMMIT, 0, rand_bytes());
    issue(CMD_COMMIT, 0, rand_bytes());
    issue(CMD_PWRITE, 1, rand_bytes());
    issue(CMD_RESERVE, 1023, rand_bytes());
    issue(CMD_READ, 6, rand_bytes());
    // A full-length skip and a skip of one bring the reader back where it was.
    issue(CMD_SKIP, 1023, rand_bytes());
    issue(CMD_SKIP, 1, rand_bytes());
    issue(CMD_SKIP, 0, rand_bytes());

    // Walk the writer once around the ring so that no byte is left unwritten.
    repeat (DEPTH / LANE_BYTES + 2) begin
      issue(CMD_WRITE, LANE_BYTES, rand_bytes());
      issue(CMD_READ, LANE_BYTES, rand_bytes());
    end

    // Random traffic; the mode leans toward filling, draining or neither.
    while (beats_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      wr_w = (mode == 0) ? 55 : (mode == 1) ? 17 : 36;
      rd_w = (mode == 0) ? 17 : (mode == 1) ? 55 : 36;
      pick = $urandom_range(0, 99);
      if (pick < wr_w) issue(CMD_WRITE, data_len(), rand_bytes());
      else if (pick < wr_w + rd_w) issue(CMD_READ, data_len(), rand_bytes());
      else if (pick < wr_w + rd_w + 10) reservation_run();
      else if (pick < wr_w + rd_w + 18) begin
        issue(CMD_SKIP, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                    : $urandom_range(0, 16), rand_bytes());
      end else begin
        case ($urandom_range(0, 2))
          0: issue(CMD_SPARE, $urandom_range(0, 1023), rand_bytes());
          1: issue(CMD_COMMIT, $urandom_range(0, 1023), rand_bytes());
          default: issue(CMD_PWRITE, data_len(), rand_bytes());
        endcase
      end
    end

    // Close, then random commands from the whole code range against a closed FIFO.
    issue(CMD_CLOSE, $urandom_range(0, 1023), rand_bytes());
    repeat (50) begin
      op = CMD_W'($urandom_range(0, 7));
      issue(op, (op == CMD_SKIP || op == CMD_RESERVE) ? $urandom_range(0, 1023) : data_len(),
            rand_bytes());
    end

    // Drain: wait for every owed reply, then a little longer for strays.
    @(negedge clk);
    start <= 1'b0;
    @(posedge clk);
    while (replies_owed != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_total == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/brfr_pkg.sv
rtl/brfr_ram.sv
rtl/brfr_lane.sv
rtl/brfr_merge.sv
rtl/byte_ring_fifo_with_reservation_core.sv
test/brfr_checker.sv
test/tb.sv
